FILE: src/cbd_pkg.sv
// ----------------------------------------------------------------------------
// cbd_pkg
// Shared types and constants of the console bus decoder with sprite DMA.
// ----------------------------------------------------------------------------
package cbd_pkg;

  localparam int RAM_DEPTH_DEF  = 2048;
  localparam int CPU_DIVIDE_DEF = 3;

  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    TGT_NONE = 3'd0,
    TGT_PPU  = 3'd1,
    TGT_APU  = 3'd2,
    TGT_CART = 3'd3,
    TGT_OAM  = 3'd4
  } target_t;

  localparam logic [15:0] RAM_LAST  = 16'h1FFF;
  localparam logic [15:0] PPU_LAST  = 16'h3FFF;
  localparam logic [15:0] DMA_REG   = 16'h4014;
  localparam logic [15:0] PAD0_REG  = 16'h4016;
  localparam logic [15:0] PAD1_REG  = 16'h4017;
  localparam logic [15:0] APU_LAST  = 16'h401F;
  localparam logic [15:0] CART_BASE = 16'h4020;
  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] addr;
    logic [7:0]  wdata;
    logic        peek_only;
    logic [7:0]  pad0_buttons;
    logic [7:0]  pad1_buttons;
    logic [7:0]  ext_rdata;
    logic        ppu_nmi;
    logic        ppu_frame_done;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  rdata;
    logic        ok;
    logic [2:0]  target;
    logic [15:0] fwd_addr;
    logic [7:0]  fwd_wdata;
    logic        fwd_write;
    logic        fwd_peek;
    logic        cpu_enable;
    logic [15:0] frame_cycles;
    logic        cpu_nmi;
    logic        frame_done;
  } out_item_t;

  // decoded item on its way to the output register
  typedef struct packed {
    out_item_t res;
    logic      ram_rd;   // rdata comes from the work RAM read port
    logic      dma_rd;   // byte read is captured as the DMA latch
    logic      dma_wr;   // fwd_wdata comes from the DMA latch
  } dec_t;

endpackage

FILE: src/cbd_in_if.sv
// ----------------------------------------------------------------------------
// cbd_in_if
// Input channel: bus access or master tick.
// ----------------------------------------------------------------------------
interface cbd_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [15:0] addr;
  logic [7:0]  wdata;
  logic        peek_only;
  logic [7:0]  pad0_buttons;
  logic [7:0]  pad1_buttons;
  logic [7:0]  ext_rdata;
  logic        ppu_nmi;
  logic        ppu_frame_done;

  modport source (
    output valid, cmd, addr, wdata, peek_only, pad0_buttons, pad1_buttons,
           ext_rdata, ppu_nmi, ppu_frame_done,
    input  ready
  );
  modport sink (
    input  valid, cmd, addr, wdata, peek_only, pad0_buttons, pad1_buttons,
           ext_rdata, ppu_nmi, ppu_frame_done,
    output ready
  );
endinterface

FILE: src/cbd_out_if.sv
// ----------------------------------------------------------------------------
// cbd_out_if
// Output channel: one result per accepted item.
// ----------------------------------------------------------------------------
interface cbd_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  rdata;
  logic        ok;
  logic [2:0]  target;
  logic [15:0] fwd_addr;
  logic [7:0]  fwd_wdata;
  logic        fwd_write;
  logic        fwd_peek;
  logic        cpu_enable;
  logic [15:0] frame_cycles;
  logic        cpu_nmi;
  logic        frame_done;

  modport source (
    output valid, rdata, ok, target, fwd_addr, fwd_wdata, fwd_write, fwd_peek,
           cpu_enable, frame_cycles, cpu_nmi, frame_done,
    input  ready
  );
  modport sink (
    input  valid, rdata, ok, target, fwd_addr, fwd_wdata, fwd_write, fwd_peek,
           cpu_enable, frame_cycles, cpu_nmi, frame_done,
    output ready
  );
endinterface

FILE: src/cbd_ram.sv
// ----------------------------------------------------------------------------
// cbd_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module cbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: src/cbd_decode.sv
// ----------------------------------------------------------------------------
// cbd_decode
// Address decode, controller shifters, DMA sequencer, tick divider and
// frame counter. Issues the work RAM reads and writes of the items that address it.
// ----------------------------------------------------------------------------
module cbd_decode
  import cbd_pkg::*;
#(
  parameter int RAM_DEPTH  = RAM_DEPTH_DEF,
  parameter int CPU_DIVIDE = CPU_DIVIDE_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  in_item_t                     item,
  output dec_t                         dec,
  output logic                         ram_re,
  output logic [$clog2(RAM_DEPTH)-1:0] ram_raddr,
  output logic                         ram_we,
  output logic [$clog2(RAM_DEPTH)-1:0] ram_waddr,
  output logic [7:0]                   ram_wdata
);

  localparam int RAM_AW = $clog2(RAM_DEPTH);
  localparam int PH_W   = (CPU_DIVIDE > 1) ? $clog2(CPU_DIVIDE) : 1;
  localparam logic [PH_W-1:0] PH_LAST = PH_W'(CPU_DIVIDE - 1);

  logic [7:0]      pad_shift [2];
  logic [7:0]      pad_shift_next [2];
  logic [PH_W-1:0] tick_phase, tick_phase_next;
  logic            dma_active, dma_active_next;
  logic [7:0]      dma_page, dma_page_next;
  logic [7:0]      dma_index, dma_index_next;
  logic            dma_odd, dma_odd_next;
  logic [15:0]     frame_count, frame_count_next;

  logic [15:0] rd_addr;
  logic        rd_peek;
  logic        do_read;
  logic        dma_step;
  logic [15:0] fc_inc;

  always_comb begin
    dec              = '0;
    pad_shift_next   = pad_shift;
    tick_phase_next  = tick_phase;
    dma_active_next  = dma_active;
    dma_page_next    = dma_page;
    dma_index_next   = dma_index;
    dma_odd_next     = dma_odd;
    frame_count_next = frame_count;
    ram_we           = 1'b0;
    ram_waddr        = item.addr[RAM_AW-1:0];
    ram_wdata        = item.wdata;

    dma_step = (item.cmd == CMD_TICK) && (tick_phase == '0) && dma_active;
    do_read  = (item.cmd == CMD_READ) || (dma_step && !dma_odd);
    rd_addr  = (item.cmd == CMD_TICK) ? {dma_page, dma_index} : item.addr;
    rd_peek  = (item.cmd == CMD_READ) && item.peek_only;
    fc_inc   = (frame_count == COUNT_MAX) ? frame_count : frame_count + 16'd1;

    dec.res.frame_cycles = frame_count;

    if (do_read) begin
      dec.res.ok = 1'b1;
      dec.dma_rd = (item.cmd == CMD_TICK);
      if (rd_addr <= RAM_LAST) begin
        dec.ram_rd = 1'b1;
      end else if (rd_addr <= PPU_LAST) begin
        dec.res.rdata  = item.ext_rdata;
        dec.res.target = TGT_PPU;
      end else if (rd_addr == PAD0_REG || rd_addr == PAD1_REG) begin
        dec.res.rdata = {7'd0, pad_shift[rd_addr[0]][7]};
        pad_shift_next[rd_addr[0]] = {pad_shift[rd_addr[0]][6:0], 1'b0};
      end else if (rd_addr >= CART_BASE) begin
        dec.res.rdata  = item.ext_rdata;
        dec.res.target = TGT_CART;
      end else begin
        dec.res.rdata  = item.ext_rdata;
        dec.res.target = TGT_APU;
      end
      if (dec.res.target != TGT_NONE) begin
        dec.res.fwd_addr = rd_addr;
        dec.res.fwd_peek = rd_peek;
      end
    end

    case (item.cmd)
      CMD_WRITE: begin
        dec.res.ok = 1'b1;
        if (item.addr <= RAM_LAST) begin
          ram_we = accept;
        end else if (item.addr == PAD0_REG || item.addr == PAD1_REG) begin
          pad_shift_next[item.addr[0]] =
            item.addr[0] ? item.pad1_buttons : item.pad0_buttons;
        end else if (item.addr == DMA_REG) begin
          dma_page_next   = item.wdata;
          dma_index_next  = 8'd0;
          dma_active_next = 1'b1;
          dma_odd_next    = 1'b0;
        end else begin
          if (item.addr <= PPU_LAST) begin
            dec.res.target = TGT_PPU;
          end else if (item.addr <= APU_LAST) begin
            dec.res.target = TGT_APU;
          end else begin
            dec.res.target = TGT_CART;
          end
          dec.res.fwd_addr  = item.addr;
          dec.res.fwd_wdata = item.wdata;
          dec.res.fwd_write = 1'b1;
        end
      end
      CMD_TICK: begin
        if (tick_phase == '0) begin
          if (dma_active) begin
            if (dma_odd) begin
              dec.res.target   = TGT_OAM;
              dec.res.fwd_addr = {8'd0, dma_index};
              dec.res.fwd_write = 1'b1;
              dec.res.ok       = 1'b1;
              dec.dma_wr       = 1'b1;
              dma_index_next   = dma_index + 8'd1;
              if (dma_index == 8'hFF) begin
                dma_active_next = 1'b0;
              end
            end
            dma_odd_next = !dma_odd;
          end else begin
            dec.res.cpu_enable = 1'b1;
          end
          frame_count_next     = fc_inc;
          dec.res.frame_cycles = fc_inc;
        end
        dec.res.cpu_nmi = item.ppu_nmi;
        tick_phase_next = (tick_phase == PH_LAST) ? '0 : tick_phase + PH_W'(1);
        if (item.ppu_frame_done) begin
          dec.res.frame_done = 1'b1;
          frame_count_next   = 16'd0;
        end
      end
      default: begin
      end
    endcase

    ram_re    = accept && do_read && (rd_addr <= RAM_LAST);
    ram_raddr = rd_addr[RAM_AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pad_shift[0] <= 8'd0;
      pad_shift[1] <= 8'd0;
      tick_phase   <= '0;
      dma_active   <= 1'b0;
      dma_page     <= 8'd0;
      dma_index    <= 8'd0;
      dma_odd      <= 1'b0;
      frame_count  <= 16'd0;
    end else if (accept) begin
      pad_shift[0] <= pad_shift_next[0];
      pad_shift[1] <= pad_shift_next[1];
      tick_phase   <= tick_phase_next;
      dma_active   <= dma_active_next;
      dma_page     <= dma_page_next;
      dma_index    <= dma_index_next;
      dma_odd      <= dma_odd_next;
      frame_count  <= frame_count_next;
    end
  end

endmodule

FILE: src/console_bus_decode_oam_dma_top.sv
// ----------------------------------------------------------------------------
// console_bus_decode_oam_dma_top
// CPU bus decoder with mirrored work RAM, controller ports and sprite DMA.
//
//   channel  dir  handshake      content
//   in_ch    in   valid/ready    read, write or master tick
//   out_ch   out  valid/ready    one result per input transfer
//
// One transfer per clock unless the output stalls; a result passes through the
// decode register (with the registered work RAM read) and the output register.
// After reset the work RAM is zeroed, all RAM_DEPTH words (2048 by default);
// in_ch.ready stays low until then.
// A stalled output holds the decode stage and the RAM read data in place.
// ----------------------------------------------------------------------------
module console_bus_decode_oam_dma_top
  import cbd_pkg::*;
#(
  parameter int RAM_DEPTH  = RAM_DEPTH_DEF,
  parameter int CPU_DIVIDE = CPU_DIVIDE_DEF
) (
  input  logic      clk,
  input  logic      rst,
  cbd_in_if.sink    in_ch,
  cbd_out_if.source out_ch
);

  localparam int RAM_AW = $clog2(RAM_DEPTH);

  logic [RAM_AW:0]   clr_cnt;
  logic              clearing;
  in_item_t          item;
  logic              accept;
  dec_t              dec;
  dec_t              s1;
  logic              s1_valid;
  logic              s1_adv;
  logic [7:0]        dma_latch;
  logic [7:0]        s1_byte;
  out_item_t         s1_res;
  out_item_t         out_res;
  logic              out_valid;
  logic              ram_re;
  logic [RAM_AW-1:0] ram_raddr;
  logic              dec_we;
  logic [RAM_AW-1:0] dec_waddr;
  logic [7:0]        dec_wdata;
  logic              ram_we;
  logic [RAM_AW-1:0] ram_waddr;
  logic [7:0]        ram_wdata;
  logic [7:0]        ram_q;

  assign clearing = !clr_cnt[RAM_AW];

  assign item = '{
    cmd:            in_ch.cmd,
    addr:           in_ch.addr,
    wdata:          in_ch.wdata,
    peek_only:      in_ch.peek_only,
    pad0_buttons:   in_ch.pad0_buttons,
    pad1_buttons:   in_ch.pad1_buttons,
    ext_rdata:      in_ch.ext_rdata,
    ppu_nmi:        in_ch.ppu_nmi,
    ppu_frame_done: in_ch.ppu_frame_done
  };

  assign s1_adv      = !out_valid || out_ch.ready;
  assign in_ch.ready = !clearing && (!s1_valid || s1_adv);
  assign accept      = in_ch.valid && in_ch.ready;

  cbd_decode #(
    .RAM_DEPTH  (RAM_DEPTH),
    .CPU_DIVIDE (CPU_DIVIDE)
  ) u_decode (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .item      (item),
    .dec       (dec),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_we    (dec_we),
    .ram_waddr (dec_waddr),
    .ram_wdata (dec_wdata)
  );

  assign ram_we    = clearing || dec_we;
  assign ram_waddr = clearing ? clr_cnt[RAM_AW-1:0] : dec_waddr;
  assign ram_wdata = clearing ? 8'd0 : dec_wdata;

  cbd_ram #(
    .WIDTH (8),
    .DEPTH (RAM_DEPTH)
  ) u_work_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  always_comb begin
    s1_byte = s1.ram_rd ? ram_q : s1.res.rdata;
    s1_res  = s1.res;
    s1_res.rdata = s1_byte;
    if (s1.dma_wr) begin
      s1_res.fwd_wdata = dma_latch;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt   <= '0;
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      dma_latch <= 8'd0;
    end else begin
      if (clearing) begin
        clr_cnt <= clr_cnt + (RAM_AW+1)'(1);
      end
      if (accept) begin
        s1_valid <= 1'b1;
        s1       <= dec;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        out_valid <= s1_valid;
        if (s1_valid) begin
          out_res <= s1_res;
          if (s1.dma_rd) begin
            dma_latch <= s1_byte;
          end
        end
      end
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.rdata        = out_res.rdata;
  assign out_ch.ok           = out_res.ok;
  assign out_ch.target       = out_res.target;
  assign out_ch.fwd_addr     = out_res.fwd_addr;
  assign out_ch.fwd_wdata    = out_res.fwd_wdata;
  assign out_ch.fwd_write    = out_res.fwd_write;
  assign out_ch.fwd_peek     = out_res.fwd_peek;
  assign out_ch.cpu_enable   = out_res.cpu_enable;
  assign out_ch.frame_cycles = out_res.frame_cycles;
  assign out_ch.cpu_nmi      = out_res.cpu_nmi;
  assign out_ch.frame_done   = out_res.frame_done;

  a_no_accept_while_clearing: assert property (
    @(posedge clk) disable iff (rst) clearing |-> !in_ch.ready
  ) else $error("input taken during RAM clear");

  a_ram_data_held: assert property (
    @(posedge clk) disable iff (rst) (s1_valid && !s1_adv) |=> $stable(ram_q)
  ) else $error("RAM read data lost under output stall");

  a_oam_is_write: assert property (
    @(posedge clk) disable iff (rst)
      (out_valid && out_res.target == TGT_OAM) |-> (out_res.fwd_write && out_res.ok)
  ) else $error("OAM transfer without write");

  a_cpu_held_during_dma: assert property (
    @(posedge clk) disable iff (rst)
      (out_valid && out_res.cpu_enable) |-> (!out_res.ok && out_res.target == TGT_NONE)
  ) else $error("CPU enabled on a DMA step");

endmodule
